// File: hw/rtl/detection_box_filter_nms_top_defines.svh
// assertion macros shared by the rtl
`ifndef DETECTION_BOX_FILTER_NMS_TOP_DEFINES_SVH
`define DETECTION_BOX_FILTER_NMS_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DBFN_ASSERT_ALWAYS(lbl, ck, rs, e) \
  lbl: assert property (@(posedge ck) disable iff (rs) (e)) else $error("check failed");
`define DBFN_ASSERT_IMPLY(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) else $error("check failed");
`define DBFN_ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) else $error("check failed");
`else
`define DBFN_ASSERT_ALWAYS(lbl, ck, rs, e)
`define DBFN_ASSERT_IMPLY(lbl, ck, rs, pre, post)
`define DBFN_ASSERT_NEXT(lbl, ck, rs, pre, post)
`endif
`endif

// File: hw/rtl/dbfn_pkg.sv
package dbfn_pkg;

  localparam int MAX_KEPT_DEF = 64;

  localparam logic [7:0] REG_SCORE_THR   = 8'd0;
  localparam logic [7:0] REG_OVERLAP_THR = 8'd1;
  localparam logic [7:0] REG_PAD_W       = 8'd2;
  localparam logic [7:0] REG_PAD_H       = 8'd3;
  localparam logic [7:0] REG_INV_SCALE   = 8'd4;
  localparam logic [7:0] REG_SRC_W       = 8'd5;
  localparam logic [7:0] REG_SRC_H       = 8'd6;
  localparam logic [7:0] REG_CLASS_MASK  = 8'd7;

  typedef struct packed {
    logic        vld;
    logic        sup;
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] x2;
    logic [15:0] y2;
    logic [15:0] score;
    logic [7:0]  cls;
    logic [31:0] area;
  } box_t;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctl_t;

  typedef struct packed {
    logic item;
    logic keep;
    logic last;
    box_t box;
  } front_out_t;

  typedef struct packed {
    logic [15:0] score_thr;
    logic [15:0] overlap_thr;
    logic [11:0] pad_w;
    logic [11:0] pad_h;
    logic [23:0] scale_recip;
    logic [11:0] src_w;
    logic [11:0] src_h;
    logic [63:0] class_mask;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IN,
    ST_POP,
    ST_CMP,
    ST_FLUSH
  } nms_state_t;

endpackage

// File: hw/rtl/detection_box_filter_nms_top.sv
// channel   | handshake           | payload
// ----------+---------------------+-----------------------------------------------
// raw in    | in_valid / in_stall | net_x1 net_y1 net_x2 net_y2 raw_score raw_class
//           |                     | last_raw
// result    | res_valid/res_stall | det_x1 det_y1 det_x2 det_y2 det_score det_class
//           |                     | det_valid last_result store_overflow
// config    | cfg_valid/cfg_ready | cfg_index cfg_data
//
// raw boxes are taken one per cycle while in_stall is low; a box passes the
// filter, scale, clip and area registers before it reaches the sorted cell
// chain. after the last box the suppression pass drops each box already
// suppressed from the chain head and makes MAX_KEPT rotations per kept box; a
// rotation waits on the shared overlap unit when it checks a same-class box.
// reset (rst, synchronous) empties the chain and restores the register defaults.
// in_stall stays high from the last box of a frame until its final result is
// registered; res_stall holds the result register and pauses the pass while a
// kept box waits for it.
`include "detection_box_filter_nms_top_defines.svh"

module detection_box_filter_nms_top #(
  parameter int MAX_KEPT = dbfn_pkg::MAX_KEPT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // raw box requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] net_x1,
  input  logic [15:0] net_y1,
  input  logic [15:0] net_x2,
  input  logic [15:0] net_y2,
  input  logic [15:0] raw_score,
  input  logic [7:0]  raw_class,
  input  logic        last_raw,
  // result requests
  output logic        res_valid,
  input  logic        res_stall,
  output logic [15:0] det_x1,
  output logic [15:0] det_y1,
  output logic [15:0] det_x2,
  output logic [15:0] det_y2,
  output logic [15:0] det_score,
  output logic [7:0]  det_class,
  output logic        det_valid,
  output logic        last_result,
  output logic        store_overflow,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_KEPT + 1);
  localparam int RC_W  = $clog2(MAX_KEPT);

  dbfn_pkg::cfg_t       cfg;
  dbfn_pkg::front_out_t fo;
  dbfn_pkg::cell_ctl_t  ctl;
  dbfn_pkg::box_t       cells [MAX_KEPT];
  logic                 ge [MAX_KEPT];
  dbfn_pkg::box_t       tail;

  dbfn_pkg::nms_state_t state, state_next;
  logic                 drain, drain_next;
  logic [CNT_W-1:0]     count, count_next;
  logic                 ovf, ovf_next;
  dbfn_pkg::box_t       pend, pend_next;
  logic                 pend_vld, pend_vld_next;
  logic                 issued, issued_next;
  logic [RC_W-1:0]      rot_cnt, rot_cnt_next;

  logic                 in_acc, out_free, need_cmp, advance;
  logic                 push, push_det, push_last;
  dbfn_pkg::box_t       push_box;
  logic                 iou_start, iou_done, iou_hit;

  assign cfg_ready = 1'b1;
  assign in_stall  = drain;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !res_valid || !res_stall;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_thr   <= 16'd16384;
      cfg.overlap_thr <= 16'd29491;
      cfg.pad_w       <= 12'd0;
      cfg.pad_h       <= 12'd0;
      cfg.scale_recip <= 24'd65536;
      cfg.src_w       <= 12'd640;
      cfg.src_h       <= 12'd640;
      cfg.class_mask  <= 64'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dbfn_pkg::REG_SCORE_THR:   cfg.score_thr   <= cfg_data[15:0];
        dbfn_pkg::REG_OVERLAP_THR: cfg.overlap_thr <= cfg_data[15:0];
        dbfn_pkg::REG_PAD_W:       cfg.pad_w       <= cfg_data[11:0];
        dbfn_pkg::REG_PAD_H:       cfg.pad_h       <= cfg_data[11:0];
        dbfn_pkg::REG_INV_SCALE:   cfg.scale_recip <= cfg_data[23:0];
        dbfn_pkg::REG_SRC_W:       cfg.src_w       <= cfg_data[11:0];
        dbfn_pkg::REG_SRC_H:       cfg.src_h       <= cfg_data[11:0];
        dbfn_pkg::REG_CLASS_MASK:  cfg.class_mask  <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter, unpad, scale, clip, area
  dbfn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .acc       (in_acc),
    .net_x1    (net_x1),
    .net_y1    (net_y1),
    .net_x2    (net_x2),
    .net_y2    (net_y2),
    .raw_score (raw_score),
    .raw_class (raw_class),
    .last_raw  (last_raw),
    .cfg       (cfg),
    .fo        (fo)
  );

  // sorted chain: insertion keeps falling score order, rotation in the compare
  // state feeds the head back to the tail through the overlap check, in the pop state it drops the head
  for (genvar g = 0; g < MAX_KEPT; g++) begin : g_chain
    dbfn_pkg::box_t prev_b, next_b;
    logic           prev_g;
    if (g == 0) begin : g_first
      assign prev_b = fo.box;
      assign prev_g = 1'b1;
    end else begin : g_mid
      assign prev_b = cells[g-1];
      assign prev_g = ge[g-1];
    end
    if (g == MAX_KEPT - 1) begin : g_last
      assign next_b = tail;
    end else begin : g_body
      assign next_b = cells[g+1];
    end
    dbfn_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .new_box  (fo.box),
      .prev_box (prev_b),
      .prev_ge  (prev_g),
      .next_box (next_b),
      .box      (cells[g]),
      .ge       (ge[g])
    );
  end

  // shared overlap unit, kept box against the chain head
  dbfn_iou u_iou (
    .clk   (clk),
    .rst   (rst),
    .start (iou_start),
    .a     (pend),
    .b     (cells[0]),
    .thr   (cfg.overlap_thr),
    .done  (iou_done),
    .hit   (iou_hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dbfn_pkg::ST_IN;
      drain    <= 1'b0;
      count    <= '0;
      ovf      <= 1'b0;
      pend_vld <= 1'b0;
      issued   <= 1'b0;
      rot_cnt  <= '0;
    end else begin
      state    <= state_next;
      drain    <= drain_next;
      count    <= count_next;
      ovf      <= ovf_next;
      pend_vld <= pend_vld_next;
      issued   <= issued_next;
      rot_cnt  <= rot_cnt_next;
    end
    pend <= pend_next;
  end

  always_comb begin
    state_next    = state;
    drain_next    = drain;
    count_next    = count;
    ovf_next      = ovf;
    pend_next     = pend;
    pend_vld_next = pend_vld;
    issued_next   = issued;
    rot_cnt_next  = rot_cnt;
    ctl           = '0;
    tail          = '0;
    push          = 1'b0;
    push_det      = 1'b1;
    push_last     = 1'b0;
    push_box      = pend;
    iou_start     = 1'b0;
    advance       = 1'b0;
    need_cmp      = cells[0].vld && !cells[0].sup && (cells[0].cls == pend.cls);

    if (in_acc && last_raw) begin
      drain_next = 1'b1;
    end

    case (state)
      dbfn_pkg::ST_IN: begin
        if (fo.item && fo.keep) begin
          if (count < CNT_W'(MAX_KEPT)) begin
            ctl.ins    = 1'b1;
            count_next = count + 1'b1;
          end else begin
            ovf_next = 1'b1;
          end
        end
        if (fo.item && fo.last) begin
          state_next = dbfn_pkg::ST_POP;
        end
      end
      dbfn_pkg::ST_POP: begin
        if (!cells[0].vld) begin
          state_next = dbfn_pkg::ST_FLUSH;
        end else if (cells[0].sup) begin
          ctl.rot = 1'b1;
        end else if (!pend_vld || out_free) begin
          // previous kept box is known not to be the last one now
          ctl.rot       = 1'b1;
          push          = pend_vld;
          pend_next     = cells[0];
          pend_vld_next = 1'b1;
          rot_cnt_next  = '0;
          issued_next   = 1'b0;
          state_next    = dbfn_pkg::ST_CMP;
        end
      end
      dbfn_pkg::ST_CMP: begin
        if (!need_cmp) begin
          ctl.rot = 1'b1;
          tail    = cells[0];
          advance = 1'b1;
        end else if (!issued) begin
          iou_start   = 1'b1;
          issued_next = 1'b1;
        end else if (iou_done) begin
          ctl.rot     = 1'b1;
          tail        = cells[0];
          tail.sup    = iou_hit;
          issued_next = 1'b0;
          advance     = 1'b1;
        end
        if (advance) begin
          if (rot_cnt == RC_W'(MAX_KEPT - 1)) begin
            state_next = dbfn_pkg::ST_POP;
          end else begin
            rot_cnt_next = rot_cnt + 1'b1;
          end
        end
      end
      dbfn_pkg::ST_FLUSH: begin
        if (out_free) begin
          push          = 1'b1;
          push_last     = 1'b1;
          push_det      = pend_vld;
          // empty frame marker carries zero fields
          push_box      = pend_vld ? pend : '0;
          pend_vld_next = 1'b0;
          ovf_next      = 1'b0;
          count_next    = '0;
          drain_next    = 1'b0;
          state_next    = dbfn_pkg::ST_IN;
        end
      end
      default: begin
        state_next = dbfn_pkg::ST_IN;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (push) begin
      det_x1         <= push_box.x1;
      det_y1         <= push_box.y1;
      det_x2         <= push_box.x2;
      det_y2         <= push_box.y2;
      det_score      <= push_box.score;
      det_class      <= push_box.cls;
      det_valid      <= push_det;
      last_result    <= push_last;
      store_overflow <= ovf;
    end
  end

  `DBFN_ASSERT_ALWAYS(a_count_cap, clk, rst, count <= CNT_W'(MAX_KEPT))
  `DBFN_ASSERT_IMPLY(a_sorted, clk, rst, (state == dbfn_pkg::ST_IN) && cells[1].vld, cells[0].vld && (cells[0].score >= cells[1].score))
  `DBFN_ASSERT_IMPLY(a_iou_owned, clk, rst, iou_done, (state == dbfn_pkg::ST_CMP) && issued)
  `DBFN_ASSERT_NEXT(a_flush_ends, clk, rst, (state == dbfn_pkg::ST_FLUSH) && out_free, (state == dbfn_pkg::ST_IN) && !drain && res_valid && last_result)

endmodule

// File: hw/rtl/dbfn_front.sv
module dbfn_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  logic [15:0]        net_x1,
  input  logic [15:0]        net_y1,
  input  logic [15:0]        net_x2,
  input  logic [15:0]        net_y2,
  input  logic [15:0]        raw_score,
  input  logic [7:0]         raw_class,
  input  logic               last_raw,
  input  dbfn_pkg::cfg_t     cfg,
  output dbfn_pkg::front_out_t fo
);

  // stage 1: filter and padding removal
  logic        s1_item, s1_keep, s1_last;
  logic [15:0] s1_score;
  logic [7:0]  s1_cls;
  logic [17:0] v1 [4];
  // stage 2: scaled
  logic        s2_item, s2_keep, s2_last;
  logic [15:0] s2_score;
  logic [7:0]  s2_cls;
  logic [22:0] c2 [4];
  // stage 3: clipped
  logic        s3_item, s3_keep, s3_last;
  logic [15:0] s3_score;
  logic [7:0]  s3_cls;
  logic [15:0] c3 [4];
  // stage 4: area
  logic        s4_item, s4_keep, s4_last;
  logic [15:0] s4_score;
  logic [7:0]  s4_cls;
  logic [15:0] c4 [4];
  logic [31:0] s4_area;

  logic        cls_ok, keep1, keep3;
  logic [15:0] raw [4];
  logic [17:0] v1_next [4];
  logic [22:0] c2_next [4];
  logic [15:0] c3_next [4];
  logic [38:0] prod;
  logic [15:0] lim;

  assign raw[0] = net_x1;
  assign raw[1] = net_y1;
  assign raw[2] = net_x2;
  assign raw[3] = net_y2;

  always_comb begin
    cls_ok = (cfg.class_mask == 64'd0) ||
             ((raw_class[7:6] == 2'd0) && cfg.class_mask[raw_class[5:0]]);
    keep1 = (raw_score >= cfg.score_thr) && cls_ok;
    for (int k = 0; k < 4; k++) begin
      v1_next[k] = {{2{raw[k][15]}}, raw[k]} -
                   {3'd0, ((k % 2) == 1) ? cfg.pad_h : cfg.pad_w, 3'd0};
    end
  end

  always_comb begin
    prod = '0;
    for (int k = 0; k < 4; k++) begin
      prod = 39'(v1[k][14:0]) * 39'(cfg.scale_recip);
      if (!v1[k][17] && (v1[k] != 18'd0)) begin
        c2_next[k] = prod[38:16];
      end else begin
        c2_next[k] = 23'd0;
      end
    end
  end

  always_comb begin
    lim = '0;
    for (int k = 0; k < 4; k++) begin
      lim = {((k % 2) == 1) ? cfg.src_h : cfg.src_w, 4'd0};
      c3_next[k] = (c2[k] < {7'd0, lim}) ? c2[k][15:0] : lim;
    end
    keep3 = s2_keep && (c3_next[0] < c3_next[2]) && (c3_next[1] < c3_next[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_item <= 1'b0;
      s2_item <= 1'b0;
      s3_item <= 1'b0;
      s4_item <= 1'b0;
    end else begin
      s1_item <= acc;
      s2_item <= s1_item;
      s3_item <= s2_item;
      s4_item <= s3_item;
    end
    s1_keep  <= keep1;
    s1_last  <= last_raw;
    s1_score <= raw_score;
    s1_cls   <= raw_class;
    s2_keep  <= s1_keep;
    s2_last  <= s1_last;
    s2_score <= s1_score;
    s2_cls   <= s1_cls;
    s3_keep  <= keep3;
    s3_last  <= s2_last;
    s3_score <= s2_score;
    s3_cls   <= s2_cls;
    s4_keep  <= s3_keep;
    s4_last  <= s3_last;
    s4_score <= s3_score;
    s4_cls   <= s3_cls;
    s4_area  <= 32'(c3[2] - c3[0]) * 32'(c3[3] - c3[1]);
    for (int k = 0; k < 4; k++) begin
      v1[k] <= v1_next[k];
      c2[k] <= c2_next[k];
      c3[k] <= c3_next[k];
      c4[k] <= c3[k];
    end
  end

  always_comb begin
    fo.item      = s4_item;
    fo.keep      = s4_keep;
    fo.last      = s4_last;
    fo.box.vld   = 1'b1;
    fo.box.sup   = 1'b0;
    fo.box.x1    = c4[0];
    fo.box.y1    = c4[1];
    fo.box.x2    = c4[2];
    fo.box.y2    = c4[3];
    fo.box.score = s4_score;
    fo.box.cls   = s4_cls;
    fo.box.area  = s4_area;
  end

endmodule

// File: hw/rtl/dbfn_cell.sv
module dbfn_cell (
  input  logic                clk,
  input  logic                rst,
  input  dbfn_pkg::cell_ctl_t ctl,
  input  dbfn_pkg::box_t      new_box,
  input  dbfn_pkg::box_t      prev_box,
  input  logic                prev_ge,
  input  dbfn_pkg::box_t      next_box,
  output dbfn_pkg::box_t      box,
  output logic                ge
);

  dbfn_pkg::box_t box_next;

  // holds its place when its score is at least the new one (ties stay ahead)
  assign ge = box.vld && (box.score >= new_box.score);

  always_comb begin
    box_next = box;
    if (ctl.rot) begin
      box_next = next_box;
    end else if (ctl.ins && !ge) begin
      box_next = prev_ge ? new_box : prev_box;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box.vld <= 1'b0;
    end else begin
      box <= box_next;
    end
  end

endmodule

// File: hw/rtl/dbfn_iou.sv
module dbfn_iou (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  dbfn_pkg::box_t a,
  input  dbfn_pkg::box_t b,
  input  logic [15:0]    thr,
  output logic           done,
  output logic           hit
);

  logic        v1, v2, v3, v4;
  logic [31:0] inter1, inter2, inter3, inter4;
  logic [32:0] asum1, uni2, uni3;
  logic [32:0] plo3, plo4;
  logic [31:0] phi4;
  logic        nz4;
  logic [15:0] ix1, iy1, ix2, iy2, iw, ih;
  logic [48:0] prod;

  always_comb begin
    ix1 = (a.x1 > b.x1) ? a.x1 : b.x1;
    iy1 = (a.y1 > b.y1) ? a.y1 : b.y1;
    ix2 = (a.x2 < b.x2) ? a.x2 : b.x2;
    iy2 = (a.y2 < b.y2) ? a.y2 : b.y2;
    iw  = (ix2 > ix1) ? (ix2 - ix1) : 16'd0;
    ih  = (iy2 > iy1) ? (iy2 - iy1) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    inter1 <= 32'(iw) * 32'(ih);
    asum1  <= {1'b0, a.area} + {1'b0, b.area};
    inter2 <= inter1;
    uni2   <= asum1 - {1'b0, inter1};
    inter3 <= inter2;
    uni3   <= uni2;
    plo3   <= 33'(thr) * 33'(uni2[16:0]);
    inter4 <= inter3;
    plo4   <= plo3;
    nz4    <= (uni3 != 33'd0);
    phi4   <= 32'(thr) * 32'(uni3[32:17]);
  end

  // inter * 65536 > thr * union
  assign prod = {phi4[31:0], 17'd0} + {16'd0, plo4};
  assign done = v4;
  assign hit  = nz4 && ({1'b0, inter4, 16'd0} > prod);

endmodule
